[hdl/tree_depth_from_parent_labels_unit_assert.svh]
// assertion macros for the tree depth unit
`ifndef TREE_DEPTH_FROM_PARENT_LABELS_UNIT_ASSERT_SVH
`define TREE_DEPTH_FROM_PARENT_LABELS_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TDPL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TDPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tdpl_pkg.sv]
// shared types for the tree depth unit
`default_nettype none

package tdpl_pkg;

    // one node record
    typedef struct packed {
        logic [7:0] node_label;
        logic [7:0] parent_label;
        logic       last_node;
    } rec_t;

    // one tree result
    typedef struct packed {
        logic [7:0] tree_depth;
        logic [7:0] nodes_loaded;
        logic       orphan_seen;
        logic       overflow_seen;
    } res_t;

    // control from the sequencer to the label search
    typedef struct packed {
        logic write;
        logic start;
    } srch_ctl_t;

    // status from the label search
    typedef struct packed {
        logic done;
        logic orphan;
    } srch_sts_t;

    // saturation limit of the 8-bit count fields
    localparam int unsigned SAT_LIMIT = 255;

endpackage

`default_nettype wire

[hdl/tdpl_search.sv]
// label store and oldest-first parent label search
`default_nettype none

module tdpl_search #(
    parameter int unsigned MAX_NODES = 128
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire tdpl_pkg::srch_ctl_t     ctl,
    input  wire [$clog2(MAX_NODES)-1:0]  idx,
    input  wire [7:0]                    label,
    input  wire [7:0]                    plabel,
    output tdpl_pkg::srch_sts_t          sts,
    output logic [$clog2(MAX_NODES)-1:0] found
);

    localparam int unsigned IDX_W = $clog2(MAX_NODES);

    logic [7:0]       label_mem [MAX_NODES];
    logic [7:0]       rd_data_reg;
    logic             active_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] scan_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] lim_reg;
    logic [IDX_W-1:0] self_reg;
    logic [7:0]       tgt_reg;
    logic             hit;
    logic             at_end;

    // label write port and registered scan read
    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            label_mem[idx] <= label;
        end
        rd_data_reg <= label_mem[scan_reg];
    end

    // compare the entry read last cycle
    assign hit    = active_reg && rd_vld_reg && (rd_data_reg == tgt_reg);
    assign at_end = active_reg && rd_vld_reg && (rd_idx_reg == lim_reg);

    assign sts.done   = hit || at_end;
    assign sts.orphan = !hit && at_end;
    assign found      = hit ? rd_idx_reg : self_reg;

    // scan sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            active_reg <= 1'b1;
            rd_vld_reg <= 1'b0;
        end
        else if (sts.done)
        begin
            active_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else if (active_reg)
        begin
            rd_vld_reg <= 1'b1;
        end
    end

    // scan address and search context
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            scan_reg <= '0;
            lim_reg  <= idx - IDX_W'(1);
            self_reg <= idx;
            tgt_reg  <= plabel;
        end
        else if (active_reg)
        begin
            rd_idx_reg <= scan_reg;
            scan_reg   <= scan_reg + IDX_W'(1);
        end
    end

endmodule

`default_nettype wire

[hdl/tdpl_walk.sv]
// depth store and parent chain walk over all stored nodes
`default_nettype none

module tdpl_walk #(
    parameter int unsigned MAX_NODES = 128
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire [$clog2(MAX_NODES+1)-1:0]  count,
    output logic [$clog2(MAX_NODES)-1:0]   par_addr,
    input  wire [$clog2(MAX_NODES)-1:0]    par_data,
    output logic                           done,
    output logic [$clog2(MAX_NODES+1)-1:0] best
);

    localparam int unsigned IDX_W = $clog2(MAX_NODES);
    localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);

    localparam logic [2:0] WK_IDLE = 3'd0;
    localparam logic [2:0] WK_PAR  = 3'd1;
    localparam logic [2:0] WK_DEP  = 3'd2;
    localparam logic [2:0] WK_WR   = 3'd3;
    localparam logic [2:0] WK_FIN  = 3'd4;

    logic [CNT_W-1:0] depth_mem [MAX_NODES];
    logic [CNT_W-1:0] dep_rd_reg;
    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] node_reg;
    logic [IDX_W-1:0] p_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] best_reg;
    logic [CNT_W-1:0] d;
    logic             last_one;

    // depth of the current node: a root alone counts one
    assign d        = (p_reg >= node_reg) ? CNT_W'(1) : dep_rd_reg + CNT_W'(1);
    assign last_one = (CNT_W'(node_reg) + CNT_W'(1)) == cnt_reg;
    assign par_addr = node_reg;
    assign done     = (state_reg == WK_FIN);
    assign best     = best_reg;

    // depth store: parent read during the lookup step, write on the update step
    always_ff @(posedge clk)
    begin
        if (state_reg == WK_WR)
        begin
            depth_mem[node_reg] <= d;
        end
        dep_rd_reg <= depth_mem[par_data];
    end

    // step sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            WK_IDLE: if (start) state_next = WK_PAR;
            WK_PAR:  state_next = WK_DEP;
            WK_DEP:  state_next = WK_WR;
            WK_WR:   state_next = last_one ? WK_FIN : WK_PAR;
            WK_FIN:  state_next = WK_IDLE;
            default: state_next = WK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // walk context and running maximum
    always_ff @(posedge clk)
    begin
        if (state_reg == WK_IDLE && start)
        begin
            node_reg <= '0;
            cnt_reg  <= count;
            best_reg <= '0;
        end
        else if (state_reg == WK_DEP)
        begin
            p_reg <= par_data;
        end
        else if (state_reg == WK_WR)
        begin
            if (d > best_reg)
            begin
                best_reg <= d;
            end
            if (!last_one)
            begin
                node_reg <= node_reg + IDX_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[hdl/tree_depth_from_parent_labels_unit.sv]
// Tree depth unit: builds a tree from node records and reports its height.
// Input channel rec (rec_valid/rec_ready) takes one node record per
// transaction; the first record of a tree is its root. Each later record
// searches the stored labels oldest first, one label per cycle through the
// label memory read port, so the next record is accepted only after the
// search ends. A record marked last_node starts the depth walk, which
// visits each stored node in turn with a parent read, a depth read and a
// depth write, after which one result transaction appears on res
// (res_valid/res_ready). The result sits in an output register: new
// records are accepted while it waits, and a finished walk holds until the
// register is free. Records beyond MAX_NODES are dropped and flagged.
// Reset clears the counts and flags at once; memories need no clearing,
// and the unit is ready in the first cycle after reset. After each result
// the unit starts a fresh tree.
`default_nettype none
`include "tree_depth_from_parent_labels_unit_assert.svh"

module tree_depth_from_parent_labels_unit #(
    parameter int unsigned MAX_NODES = 128
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                rec_valid,
    output logic               rec_ready,
    input  wire tdpl_pkg::rec_t rec,
    output logic               res_valid,
    input  wire                res_ready,
    output tdpl_pkg::res_t     res
);

    localparam int unsigned IDX_W = $clog2(MAX_NODES);
    localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 orphan_reg;
    logic                 orphan_next;
    logic                 overflow_reg;
    logic                 overflow_next;
    logic                 last_reg;
    logic                 res_valid_reg;
    tdpl_pkg::res_t       res_reg;

    logic                 rec_acc;
    logic                 full;
    logic                 emit_go;
    tdpl_pkg::srch_ctl_t  srch_ctl;
    tdpl_pkg::srch_sts_t  srch_sts;
    logic [IDX_W-1:0]     found;
    logic [IDX_W-1:0]     wr_idx;
    logic                 walk_start;
    logic                 walk_done;
    logic [CNT_W-1:0]     walk_best;
    logic [IDX_W-1:0]     par_addr;
    logic [IDX_W-1:0]     par_rd_reg;
    logic                 par_we;
    logic [IDX_W-1:0]     par_wdata;
    logic [IDX_W-1:0]     parent_mem [MAX_NODES];
    logic [31:0]          best_ext;
    logic [31:0]          cnt_ext;

    assign rec_ready = (state_reg == ST_IDLE);
    assign rec_acc   = rec_valid && rec_ready;
    assign full      = (count_reg == CNT_W'(MAX_NODES));
    assign wr_idx    = count_reg[IDX_W-1:0];
    assign emit_go   = (state_reg == ST_EMIT) && (!res_valid_reg || res_ready);

    // label search control
    assign srch_ctl.write = rec_acc && !full;
    assign srch_ctl.start = rec_acc && !full && (count_reg != '0);

    tdpl_search #(
        .MAX_NODES (MAX_NODES)
    ) u_search (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (srch_ctl),
        .idx    (wr_idx),
        .label  (rec.node_label),
        .plabel (rec.parent_label),
        .sts    (srch_sts),
        .found  (found)
    );

    // parent index store: root points at itself
    assign par_we    = (rec_acc && !full && (count_reg == '0)) ||
                       ((state_reg == ST_SEARCH) && srch_sts.done);
    assign par_wdata = (state_reg == ST_SEARCH) ? found : '0;

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            parent_mem[wr_idx] <= par_wdata;
        end
        par_rd_reg <= parent_mem[par_addr];
    end

    assign walk_start = (state_reg == ST_START);

    tdpl_walk #(
        .MAX_NODES (MAX_NODES)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (walk_start),
        .count    (count_reg),
        .par_addr (par_addr),
        .par_data (par_rd_reg),
        .done     (walk_done),
        .best     (walk_best)
    );

    // record sequencing
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        orphan_next   = orphan_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rec_acc)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                        if (rec.last_node) state_next = ST_START;
                    end
                    else if (count_reg == '0)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        if (rec.last_node) state_next = ST_START;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (srch_sts.done)
                begin
                    count_next  = count_reg + CNT_W'(1);
                    orphan_next = orphan_reg || srch_sts.orphan;
                    state_next  = last_reg ? ST_START : ST_IDLE;
                end
            end
            ST_START: state_next = ST_WALK;
            ST_WALK:  if (walk_done) state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    count_next    = '0;
                    orphan_next   = 1'b0;
                    overflow_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            orphan_reg   <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            orphan_reg   <= orphan_next;
            overflow_reg <= overflow_next;
        end
    end

    // last-record mark held over the search
    always_ff @(posedge clk)
    begin
        if (rec_acc)
        begin
            last_reg <= rec.last_node;
        end
    end

    // saturate counts into the 8-bit result fields
    assign best_ext = 32'(walk_best);
    assign cnt_ext  = 32'(count_reg);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            res_reg.tree_depth    <= (best_ext > tdpl_pkg::SAT_LIMIT) ? 8'hFF : best_ext[7:0];
            res_reg.nodes_loaded  <= (cnt_ext > tdpl_pkg::SAT_LIMIT) ? 8'hFF : cnt_ext[7:0];
            res_reg.orphan_seen   <= orphan_reg;
            res_reg.overflow_seen <= overflow_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // checks
    `TDPL_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CNT_W'(MAX_NODES),
        "stored count above capacity")
    `TDPL_ASSERT_NOW(a_search_done_state, srch_sts.done, state_reg == ST_SEARCH,
        "label search finished outside the search phase")
    `TDPL_ASSERT_NOW(a_walk_done_state, walk_done, state_reg == ST_WALK,
        "depth walk finished outside the walk phase")
    `TDPL_ASSERT_NEXT(a_last_blocks, rec_acc && rec.last_node, !rec_ready,
        "record accepted before the tree result was formed")

endmodule

`default_nettype wire
